// ===== rtl/core/unique_request_fifo_top_defines.svh =====
// Assertion macros shared by the unique request FIFO RTL.
`ifndef UNIQUE_REQUEST_FIFO_TOP_DEFINES_SVH
`define UNIQUE_REQUEST_FIFO_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define URF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define URF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/urf_pkg.sv =====
// Types and constants of the unique request FIFO.
package urf_pkg;

   localparam int CODE_W = 4;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_POP    = 2'd2,
      CMD_NOP    = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      command_type        command;
      logic [CODE_W-1:0]  note_code;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [2:0]         position;
      logic [CODE_W-1:0]  popped_code;
      logic [3:0]         entry_count;
   } rsp_type;

endpackage

// ===== rtl/core/unique_request_fifo_top.sv =====
// Unique request FIFO: ordered queue of distinct request codes with search and gap close.
//
// Request channel (req_valid / req_stall / req_data) carries a command and a code:
// add appends a code that is not yet queued, remove deletes a code wherever it
// stands and closes the gap, pop takes out the oldest code. Each transfer yields
// exactly one response on rsp_valid / rsp_stall / rsp_data with status, position,
// popped code and the entry count after the command.
// One command at a time: req_stall is high from the transfer until the response
// is loaded into the output register. A search reads the queue RAM one entry
// at a time, from an address state to a compare state; closing the gap after a
// remove or pop moves each later entry down with a read state and a write state.
// An unused command goes from the transfer straight to the finish state.
// The response register holds its value while rsp_stall is high; the next
// command may be taken meanwhile and waits for the slot before it finishes.
// Reset empties the queue (count to zero) and drops any pending response; the
// RAM contents are not cleared since no entry is read before it is written.
`include "unique_request_fifo_top_defines.svh"

module unique_request_fifo_top #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  urf_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output urf_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   urf_pkg::command_type      cmd_ff, cmd_in;
   logic [urf_pkg::CODE_W-1:0] code_ff, code_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   urf_pkg::status_type       status_ff, status_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic [urf_pkg::CODE_W-1:0] popped_ff, popped_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   urf_pkg::rsp_type          rsp_ff, rsp_in;

   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   logic [urf_pkg::CODE_W-1:0] ram_wdata;
   logic [IDX_W-1:0]          ram_raddr;
   logic [urf_pkg::CODE_W-1:0] ram_rdata;

   logic [CNT_W-1:0]          scan_nxt;
   logic [IDX_W+2:0]          pos_wide;
   logic [CNT_W+3:0]          cnt_wide;
   logic                      req_xfer;

   urf_ram #(
      .WIDTH (urf_pkg::CODE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign scan_nxt  = scan_ff + CNT_W'(1);
   assign pos_wide  = (IDX_W + 3)'(pos_ff);
   assign cnt_wide  = (CNT_W + 4)'(count_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      code_in      = code_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      popped_in    = popped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = scan_ff[IDX_W-1:0];
      ram_wdata    = code_ff;
      ram_raddr    = scan_ff[IDX_W-1:0];

      // drop the response once it has been taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               code_in   = req_data.note_code;
               scan_in   = '0;
               status_in = urf_pkg::ST_DONE;
               pos_in    = '0;
               popped_in = '0;
               state_in  = (req_data.command == urf_pkg::CMD_NOP) ? S_FINISH : S_SEARCH_RD;
            end
         end
         S_SEARCH_RD: begin
            if (scan_ff == count_ff) begin
               // scanned every entry without a match
               unique case (cmd_ff)
                  urf_pkg::CMD_ADD: begin
                     if (count_ff == DEPTH_C) begin
                        status_in = urf_pkg::ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[IDX_W-1:0];
                        pos_in    = count_ff[IDX_W-1:0];
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  urf_pkg::CMD_REMOVE: status_in = urf_pkg::ST_NOT_FOUND;
                  urf_pkg::CMD_POP:    status_in = urf_pkg::ST_EMPTY;
                  default: ;
               endcase
               state_in = S_FINISH;
            end else begin
               state_in = S_SEARCH_CMP;
            end
         end
         S_SEARCH_CMP: begin
            // pop always matches the head entry
            if (cmd_ff == urf_pkg::CMD_POP || ram_rdata == code_ff) begin
               pos_in = scan_ff[IDX_W-1:0];
               if (cmd_ff == urf_pkg::CMD_POP) begin
                  popped_in = ram_rdata;
               end
               if (cmd_ff == urf_pkg::CMD_ADD) begin
                  status_in = urf_pkg::ST_DUPLICATE;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else begin
               scan_in  = scan_nxt;
               state_in = S_SEARCH_RD;
            end
         end
         S_SHIFT_RD: begin
            if (scan_nxt < count_ff) begin
               ram_raddr = scan_nxt[IDX_W-1:0];
               state_in  = S_SHIFT_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            // move the later entry down into the gap
            ram_we    = 1'b1;
            ram_waddr = scan_ff[IDX_W-1:0];
            ram_wdata = ram_rdata;
            scan_in   = scan_nxt;
            state_in  = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.position    = pos_wide[2:0];
               rsp_in.popped_code = popped_ff;
               rsp_in.entry_count = cnt_wide[3:0];
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      code_ff   <= code_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      popped_ff <= popped_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `URF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C, "queue count above depth")
   `URF_ASSERT_NOW(a_ram_write_state, clock, reset, ram_we, state_ff == S_SHIFT_WR || state_ff == S_SEARCH_RD, "queue RAM written outside add or shift")
   `URF_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, state_ff != S_IDLE, "sequencer idle after a request transfer")

endmodule

// ===== rtl/core/urf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module urf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the unique request FIFO: directed and random commands checked against a shadow queue.
`timescale 1ns / 100ps

module tb_top;

   localparam int DEPTH        = 8;
   localparam int DRAIN_CYCLES = 4 * DEPTH + 32;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   urf_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   urf_pkg::rsp_type rsp_data;

   // shadow copy of the queue contents
   logic [urf_pkg::CODE_W-1:0] held_codes [DEPTH];
   int unsigned                held_count = 0;
   urf_pkg::rsp_type           awaited_outcomes [$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int error_count    = 0;
   int commands_sent  = 0;
   int responses_seen = 0;
   int status_seen [5] = '{default: 0};

   unique_request_fifo_top #(.QUEUE_DEPTH(DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Apply one command to the shadow queue and return the response it must give.
   function automatic urf_pkg::rsp_type run_command(urf_pkg::req_type cmd);
      urf_pkg::rsp_type out;
      int               hit;
      int               i;
      out        = '0;
      out.status = urf_pkg::ST_DONE;
      hit        = -1;
      for (i = 0; i < int'(held_count); i++)
         if (hit < 0 && held_codes[i] == cmd.note_code) hit = i;
      case (cmd.command)
         urf_pkg::CMD_ADD: begin
            if (hit >= 0) begin
               out.status   = urf_pkg::ST_DUPLICATE;
               out.position = 3'(hit);
            end else if (held_count >= DEPTH) begin
               out.status = urf_pkg::ST_FULL;
            end else begin
               out.position           = 3'(held_count);
               held_codes[held_count] = cmd.note_code;
               held_count++;
            end
         end
         urf_pkg::CMD_REMOVE: begin
            if (hit >= 0) begin
               out.position = 3'(hit);
               // close the gap, keep the order of the rest
               for (i = hit; i + 1 < int'(held_count); i++) held_codes[i] = held_codes[i + 1];
               held_count--;
            end else begin
               out.status = urf_pkg::ST_NOT_FOUND;
            end
         end
         urf_pkg::CMD_POP: begin
            if (held_count == 0) begin
               out.status = urf_pkg::ST_EMPTY;
            end else begin
               out.popped_code = held_codes[0];
               for (i = 0; i + 1 < int'(held_count); i++) held_codes[i] = held_codes[i + 1];
               held_count--;
            end
         end
         default: ;
      endcase
      out.entry_count = 4'(held_count);
      return out;
   endfunction

   task automatic send_command(input urf_pkg::command_type command,
                               input logic [urf_pkg::CODE_W-1:0] code);
      urf_pkg::req_type item;
      item.command   = command;
      item.note_code = code;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      // hold until the transfer happens
      do @(posedge clock); while (req_stall);
      awaited_outcomes.push_back(run_command(item));
      commands_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_response(input urf_pkg::rsp_type got);
      urf_pkg::rsp_type want;
      if (awaited_outcomes.size() == 0) begin
         $display("%0t: response with nothing outstanding, actual %h", $time, got);
         error_count++;
      end else begin
         want = awaited_outcomes.pop_front();
         responses_seen++;
         compare_field("status", want.status, got.status);
         compare_field("position", want.position, got.position);
         compare_field("popped_code", want.popped_code, got.popped_code);
         compare_field("entry_count", want.entry_count, got.entry_count);
         status_seen[int'(want.status)]++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_response(rsp_data);
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Fill with the extreme codes, including code zero, then hit full and a duplicate while full.
   task automatic test_fill_to_full();
      logic [urf_pkg::CODE_W-1:0] fill [DEPTH];
      fill = '{4'd15, 4'd0, 4'd5, 4'd10, 4'd3, 4'd12, 4'd1, 4'd9};
      foreach (fill[k]) send_command(urf_pkg::CMD_ADD, fill[k]);
      send_command(urf_pkg::CMD_ADD, 4'd6);
      send_command(urf_pkg::CMD_ADD, 4'd5);
   endtask

   // Remove the head of a full queue, a middle entry, a missing code and the tail.
   task automatic test_remove_closes_gap();
      send_command(urf_pkg::CMD_REMOVE, 4'd15);
      send_command(urf_pkg::CMD_REMOVE, 4'd10);
      send_command(urf_pkg::CMD_REMOVE, 4'd7);
      send_command(urf_pkg::CMD_REMOVE, 4'd9);
   endtask

   // Pop everything (the first pop returns code zero), then pop an empty queue.
   task automatic test_pop_to_empty();
      repeat (5) send_command(urf_pkg::CMD_POP, 4'($urandom));
      send_command(urf_pkg::CMD_POP, 4'hF);
   endtask

   task automatic test_unused_command();
      send_command(urf_pkg::CMD_ADD, 4'd2);
      send_command(urf_pkg::CMD_NOP, 4'hF);
      send_command(urf_pkg::CMD_NOP, 4'h0);
      send_command(urf_pkg::CMD_REMOVE, 4'd2);
   endtask

   task automatic send_random_command(input int add_pct);
      int                         pick;
      urf_pkg::command_type       command;
      logic [urf_pkg::CODE_W-1:0] code;
      pick = $urandom_range(99);
      code = 4'($urandom_range(15));
      // favor codes already queued so duplicates and real removes are common
      if (held_count > 0 && $urandom_range(99) < 50)
         code = held_codes[$urandom_range(held_count - 1)];
      if (pick < add_pct)                           command = urf_pkg::CMD_ADD;
      else if (pick < add_pct + (95 - add_pct) / 2) command = urf_pkg::CMD_REMOVE;
      else if (pick < 95)                           command = urf_pkg::CMD_POP;
      else                                          command = urf_pkg::CMD_NOP;
      send_command(command, code);
   endtask

   // Alternate filling and draining stretches so the queue swings between empty and full.
   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < count; k++) send_random_command(((k / 40) % 2) ? 25 : 60);
      wait_for_drain();
   endtask

   task automatic test_pause_until_drained();
      send_idle_pct = 10;
      rsp_stall_pct = 64;
      repeat (20) send_random_command(50);
      wait_for_drain();
      repeat (20) send_random_command(50);
      wait_for_drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_to_full();
      test_remove_closes_gap();
      test_pop_to_empty();
      test_unused_command();
      test_random_traffic(380, 0, 0);
      test_random_traffic(380, 64, 0);
      test_random_traffic(380, 0, 64);
      test_pause_until_drained();
      test_random_traffic(380, 10, 10);
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d commands, checked %0d responses over four pacing phases and drain pauses",
               commands_sent, responses_seen);
      $display("Outcomes: %0d done, %0d duplicate, %0d full, %0d not found, %0d empty",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (error_count == 0 && awaited_outcomes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d responses outstanding", awaited_outcomes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/urf_pkg.sv
rtl/core/urf_ram.sv
rtl/core/unique_request_fifo_top.sv
sim/tb_top.sv
